// ===== rtl/fldc_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed LED command decoder package
// Shared codes and types for the frame parser and the LED update unit.
// ----------------------------------------------------------------------------
package fldc_pkg;

  localparam logic [7:0] BYTE_START = 8'h30;
  localparam logic [7:0] BYTE_ID    = 8'h31;
  localparam logic [7:0] BYTE_END   = 8'h32;
  localparam logic [7:0] MIN_LENGTH = 8'd6;

  localparam logic [7:0] CMD_PORT_LOAD = 8'h00;
  localparam logic [7:0] CMD_PORT_HIGH = 8'h01;
  localparam logic [7:0] CMD_SET_ONE   = 8'hA0;
  localparam logic [7:0] CMD_LOAD_ALL  = 8'hB0;
  localparam logic [7:0] CMD_CLEAR_ALL = 8'hC0;
  localparam logic [7:0] CMD_SET_ALL   = 8'hC1;

  localparam logic [1:0] VARIANT_FULL = 2'd0;
  localparam logic [1:0] VARIANT_LOW  = 2'd1;
  localparam logic [1:0] VARIANT_HIGH = 2'd2;

  localparam int unsigned LOW_FIELD_BITS = 23;
  localparam int unsigned HIGH_FIELD_LSB = 23;
  localparam int unsigned HIGH_FIELD_BITS = 4;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_APPLIED = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [1:0] STATUS_DROPPED = 2'd3;

  localparam logic CFG_IDX_CHECKSUM = 1'b0;
  localparam logic CFG_IDX_VARIANT  = 1'b1;

  typedef struct packed {
    logic apply;
    logic drop;
  } fldc_event_t;

endpackage

// ===== rtl/fldc_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame phase, command, length, payload head and running XOR.
// ----------------------------------------------------------------------------
module fldc_parser
  import fldc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              checksum_check_i,
  output fldc_event_t       event_o,
  output logic [7:0]        command_o,
  output logic [31:0]       payload_word_o
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CSUM = 3'd5;
  localparam logic [2:0] PH_END  = 3'd6;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      command_q, command_d;
  logic [7:0]      length_q, length_d;
  logic [7:0]      count_q, count_d;
  logic [7:0]      xor_q, xor_d;
  logic [3:0][7:0] head_q;
  logic            head_we;
  fldc_event_t     event_d;

  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    length_d  = length_q;
    count_d   = count_q;
    xor_d     = xor_q;
    head_we   = 1'b0;
    event_d   = '0;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == BYTE_START) begin
          phase_d = PH_ID;
          count_d = '0;
        end
      end
      PH_ID: begin
        if (byte_i == BYTE_ID) begin
          phase_d = PH_CMD;
        end else begin
          phase_d       = PH_HUNT;
          event_d.drop  = 1'b1;
        end
      end
      PH_CMD: begin
        command_d = byte_i;
        xor_d     = byte_i;
        phase_d   = PH_LEN;
      end
      PH_LEN: begin
        length_d = byte_i;
        xor_d    = xor_q ^ byte_i;
        if (byte_i < MIN_LENGTH) begin
          phase_d      = PH_HUNT;
          event_d.drop = 1'b1;
        end else if (byte_i == MIN_LENGTH) begin
          phase_d = PH_CSUM;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        head_we = (count_q < 8'd4);
        xor_d   = xor_q ^ byte_i;
        count_d = count_q + 8'd1;
        if (count_d == length_q - MIN_LENGTH) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (checksum_check_i && (byte_i != xor_q)) begin
          phase_d      = PH_HUNT;
          event_d.drop = 1'b1;
        end else begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        phase_d = PH_HUNT;
        if (byte_i == BYTE_END) begin
          event_d.apply = 1'b1;
        end else begin
          event_d.drop = 1'b1;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      command_q <= '0;
      length_q  <= '0;
      count_q   <= '0;
      xor_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      command_q <= command_d;
      length_q  <= length_d;
      count_q   <= count_d;
      xor_q     <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && head_we) begin
      head_q[count_q[1:0]] <= byte_i;
    end
  end

  assign event_o        = step_i ? event_d : '0;
  assign command_o      = command_q;
  assign payload_word_o = head_q;

endmodule

// ===== rtl/fldc_led_unit.sv =====
// ----------------------------------------------------------------------------
// LED update unit
// Applies a completed frame's command to the LED register and forms the status.
// ----------------------------------------------------------------------------
module fldc_led_unit
  import fldc_pkg::*;
#(
  parameter int unsigned LED_COUNT = 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  fldc_event_t          event_i,
  input  logic [7:0]           command_i,
  input  logic [31:0]          payload_word_i,
  input  logic [1:0]           port_variant_i,
  output logic [LED_COUNT-1:0] led_next_o,
  output logic [1:0]           status_o
);

  localparam int unsigned IDX_W = $clog2(LED_COUNT);

  logic [LED_COUNT-1:0] led_q, led_d;
  logic [7:0]           led_index;
  logic                 known;

  assign led_index = payload_word_i[7:0];

  always_comb begin
    led_d = led_q;
    known = 1'b1;
    priority if (command_i == CMD_PORT_LOAD && port_variant_i == VARIANT_FULL) begin
      led_d = payload_word_i[LED_COUNT-1:0];
    end else if (command_i == CMD_PORT_LOAD && port_variant_i == VARIANT_LOW) begin
      led_d[LOW_FIELD_BITS-1:0] = payload_word_i[LOW_FIELD_BITS-1:0];
    end else if (command_i == CMD_PORT_HIGH && port_variant_i == VARIANT_HIGH) begin
      led_d[HIGH_FIELD_LSB +: HIGH_FIELD_BITS] = payload_word_i[HIGH_FIELD_BITS-1:0];
    end else if (command_i == CMD_SET_ONE) begin
      if (led_index < 8'(LED_COUNT)) begin
        led_d[led_index[IDX_W-1:0]] = (payload_word_i[15:8] != 8'd0);
      end
    end else if (command_i == CMD_LOAD_ALL) begin
      led_d = payload_word_i[LED_COUNT-1:0];
    end else if (command_i == CMD_CLEAR_ALL) begin
      led_d = '0;
    end else if (command_i == CMD_SET_ALL) begin
      led_d = '1;
    end else begin
      known = 1'b0;
    end
  end

  assign led_next_o = event_i.apply ? led_d : led_q;

  always_comb begin
    priority if (event_i.apply) begin
      status_o = known ? STATUS_APPLIED : STATUS_UNKNOWN;
    end else if (event_i.drop) begin
      status_o = STATUS_DROPPED;
    end else begin
      status_o = STATUS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q <= '0;
    end else if (step_i) begin
      led_q <= led_next_o;
    end
  end

endmodule

// ===== rtl/framed_led_command_decoder.sv =====
// ----------------------------------------------------------------------------
// Framed LED command decoder
// Parses framed serial commands and drives a LED register, one result per byte.
//
//   Channel  Signals                               Direction
//   in       in_valid_i, in_ready_o, rx_byte_i      into block
//   out      out_valid_o, out_ready_i, led_bits_o,
//            frame_status_o                         out of block
//   config   cfg_we_i, cfg_idx_i, cfg_wdata_i       into block
//
// Each byte is held in the input register and is then parsed combinationally into
// the result register, so one byte is taken every cycle while the output is not stalled.
// Reset clears the parse phase, the counters and the internal LED register; the LED output register is not reset.
// A stalled output holds the input register, which then stops taking bytes.
// ----------------------------------------------------------------------------
module framed_led_command_decoder
  import fldc_pkg::*;
#(
  parameter int unsigned LED_COUNT = 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LED_COUNT-1:0] led_bits_o,
  output logic [1:0]           frame_status_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [1:0]           cfg_wdata_i
);

  logic                 in_valid_q;
  logic [7:0]           rx_byte_q;
  logic                 out_valid_q;
  logic [LED_COUNT-1:0] led_bits_q;
  logic [1:0]           status_q;
  logic                 checksum_check_q;
  logic [1:0]           port_variant_q;
  logic                 step;
  fldc_event_t          frame_event;
  logic [7:0]           command;
  logic [31:0]          payload_word;
  logic [LED_COUNT-1:0] led_next;
  logic [1:0]           status;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      checksum_check_q <= 1'b0;
      port_variant_q   <= VARIANT_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_CHECKSUM: checksum_check_q <= cfg_wdata_i[0];
        CFG_IDX_VARIANT:  port_variant_q   <= cfg_wdata_i;
        default:          checksum_check_q <= checksum_check_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  fldc_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .byte_i           (rx_byte_q),
    .checksum_check_i (checksum_check_q),
    .event_o          (frame_event),
    .command_o        (command),
    .payload_word_o   (payload_word)
  );

  fldc_led_unit #(
    .LED_COUNT (LED_COUNT)
  ) u_led_unit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .event_i        (frame_event),
    .command_i      (command),
    .payload_word_i (payload_word),
    .port_variant_i (port_variant_q),
    .led_next_o     (led_next),
    .status_o       (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      led_bits_q <= led_next;
      status_q   <= status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_bits_o     = led_bits_q;
  assign frame_status_o = status_q;

endmodule
